// ===== rtl/pcwb_pkg.sv =====
// ----------------------------------------------------------------------------
// pcwb_pkg
// Shared types, constants and helpers of the page cache writeback controller.
// ----------------------------------------------------------------------------
package pcwb_pkg;

	// Field widths fixed by the command and result formats.
	localparam int ADDR_W     = 32;
	localparam int LEN_W      = 19;
	localparam int TAG_W      = 18;
	localparam int CH_W       = 2;
	localparam int SHIFT_W    = 5;
	// Widest address a channel is taken from: an 18-bit tag times the largest page.
	localparam int CHAN_IN_W  = TAG_W + 16;

	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);

	localparam logic [SHIFT_W-1:0] CHANNEL_SHIFT_RESET = 5'd23;

	// Command kinds.
	localparam logic OP_READ  = 1'b0;
	localparam logic OP_WRITE = 1'b1;

	typedef struct packed {
		logic              op;
		logic [ADDR_W-1:0] byte_address;
		logic [LEN_W-1:0]  length_bytes;
	} cmd_t;

	typedef struct packed {
		logic [TAG_W-1:0] page_number;
		logic             hit;
		logic             writeback;
		logic [CH_W-1:0]  writeback_channel;
		logic             fetch;
		logic [CH_W-1:0]  fetch_channel;
		logic             last;
	} res_t;

	// One page access as it travels from the front to the back.
	typedef struct packed {
		logic              op;
		logic [ADDR_W-1:0] addr;
		logic              last;
	} page_req_t;

	typedef struct packed {
		logic      valid;
		page_req_t req;
	} page_push_t;

	typedef struct packed {
		logic full;
		logic empty;
	} fifo_stat_t;

	// Flash channel of an address: shifted right, saturated at the top channel.
	function automatic logic [CH_W-1:0] chan_sat(input logic [CHAN_IN_W-1:0] a,
			input logic [SHIFT_W-1:0] sh, input logic [CHAN_IN_W-1:0] top);
		logic [CHAN_IN_W-1:0] shifted;
		shifted = a >> sh;
		if (shifted > top) begin
			shifted = top;
		end
		return shifted[CH_W-1:0];
	endfunction

endpackage

// ===== rtl/pcwb_front.sv =====
// ----------------------------------------------------------------------------
// pcwb_front
// Accepts a command, counts its pages and pushes one page access per cycle while the queue is not full.
// ----------------------------------------------------------------------------
module pcwb_front #(
	parameter int PAGE_BYTES = 16384,
	parameter int MAX_PAGES  = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  pcwb_pkg::cmd_t         cmd,
	input  logic                   clearing,
	input  pcwb_pkg::fifo_stat_t   fifo_stat,
	output pcwb_pkg::page_push_t   push,
	output logic                   busy
);

	localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
	localparam int CNT_W      = $clog2(MAX_PAGES + 1);
	localparam int SUM_W      = pcwb_pkg::LEN_W + 1;

	logic [CNT_W-1:0]            rem_q;
	logic [pcwb_pkg::ADDR_W-1:0] addr_q;
	logic                        op_q;

	logic [SUM_W-1:0] len_sum;
	logic [SUM_W-1:0] pages_raw;
	logic [CNT_W-1:0] pages;
	logic             accept;
	logic             active;
	logic             do_push;

	// Page count, rounded up and saturated.
	always_comb begin
		len_sum   = SUM_W'(cmd.length_bytes) + SUM_W'(PAGE_BYTES - 1);
		pages_raw = len_sum >> PAGE_SHIFT;
		if (pages_raw > SUM_W'(MAX_PAGES)) begin
			pages = CNT_W'(MAX_PAGES);
		end else begin
			pages = pages_raw[CNT_W-1:0];
		end
	end

	assign active  = (rem_q != '0);
	assign busy    = active || clearing;
	assign accept  = start && !busy;
	assign do_push = active && !fifo_stat.full;

	assign push.valid    = do_push;
	assign push.req.op   = op_q;
	assign push.req.addr = addr_q;
	assign push.req.last = (rem_q == CNT_W'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q <= '0;
		end else if (accept) begin
			rem_q <= pages;
		end else if (do_push) begin
			rem_q <= rem_q - CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			addr_q <= cmd.byte_address;
			op_q   <= cmd.op;
		end else if (do_push) begin
			addr_q <= addr_q + pcwb_pkg::ADDR_W'(PAGE_BYTES);
		end
	end

endmodule

// ===== rtl/pcwb_fifo.sv =====
// ----------------------------------------------------------------------------
// pcwb_fifo
// Short queue of page accesses between the front and the back.
// ----------------------------------------------------------------------------
module pcwb_fifo (
	input  logic                  clk,
	input  logic                  arst_n,
	input  pcwb_pkg::page_push_t  push,
	input  logic                  pop,
	output pcwb_pkg::page_req_t   head,
	output pcwb_pkg::fifo_stat_t  stat
);

	localparam int PTR_W = pcwb_pkg::FIFO_PTR_W;

	pcwb_pkg::page_req_t entries_q [pcwb_pkg::FIFO_DEPTH];
	logic [PTR_W-1:0]    wr_ptr_q;
	logic [PTR_W-1:0]    rd_ptr_q;
	logic [PTR_W:0]      count_q;

	assign stat.full  = (count_q == (PTR_W + 1)'(pcwb_pkg::FIFO_DEPTH));
	assign stat.empty = (count_q == '0);
	assign head       = entries_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push.valid) begin
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			if (push.valid && !pop) begin
				count_q <= count_q + (PTR_W + 1)'(1);
			end else if (pop && !push.valid) begin
				count_q <= count_q - (PTR_W + 1)'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push.valid) begin
			entries_q[wr_ptr_q] <= push.req;
		end
	end

endmodule

// ===== rtl/pcwb_back.sv =====
// ----------------------------------------------------------------------------
// pcwb_back
// Clears the line store after reset, then looks up and updates one cache
// line per page access and produces the page result.
// ----------------------------------------------------------------------------
module pcwb_back #(
	parameter int LINES      = 128,
	parameter int PAGE_BYTES = 16384,
	parameter int CHANNELS   = 4
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic [pcwb_pkg::SHIFT_W-1:0]        channel_shift,
	input  pcwb_pkg::page_req_t                 head,
	input  pcwb_pkg::fifo_stat_t                fifo_stat,
	output logic                                pop,
	output logic                                clearing,
	output logic                                result_valid,
	output pcwb_pkg::res_t                      result
);

	localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
	localparam int LINE_W     = $clog2(LINES);
	localparam logic [pcwb_pkg::CHAN_IN_W-1:0] CHAN_TOP =
		pcwb_pkg::CHAN_IN_W'(CHANNELS - 1);

	typedef struct packed {
		logic                       dirty;
		logic [pcwb_pkg::TAG_W-1:0] tag;
	} line_t;

	typedef enum logic [1:0] {
		B_CLEAR,
		B_LOOK,
		B_EVAL
	} state_t;

	line_t mem [LINES];

	state_t              state_q;
	logic [LINE_W-1:0]   clr_q;
	pcwb_pkg::page_req_t entry_s1;
	line_t               rd_line_s1;
	pcwb_pkg::res_t      result_q;
	logic                result_valid_q;

	logic [LINE_W-1:0]              raddr;
	logic [LINE_W-1:0]              line_s1;
	logic [pcwb_pkg::TAG_W-1:0]     tag_s1;
	logic [pcwb_pkg::TAG_W+PAGE_SHIFT-1:0] victim_addr;
	logic                           hit;
	logic                           wb;
	logic                           fe;
	line_t                          new_line;
	logic                           mem_we;
	logic [LINE_W-1:0]              mem_waddr;
	line_t                          mem_wdata;
	pcwb_pkg::res_t                 res_next;

	assign raddr    = head.addr[PAGE_SHIFT +: LINE_W];
	assign line_s1  = entry_s1.addr[PAGE_SHIFT +: LINE_W];
	assign tag_s1   = pcwb_pkg::TAG_W'(entry_s1.addr >> PAGE_SHIFT);
	assign pop      = (state_q == B_LOOK) && !fifo_stat.empty;
	assign clearing = (state_q == B_CLEAR);

	always_comb begin
		hit         = (rd_line_s1.tag == tag_s1);
		wb          = !hit && rd_line_s1.dirty;
		fe          = !hit && (entry_s1.op == pcwb_pkg::OP_READ);
		victim_addr = {rd_line_s1.tag, {PAGE_SHIFT{1'b0}}};

		new_line.tag = tag_s1;
		if (entry_s1.op == pcwb_pkg::OP_WRITE) begin
			new_line.dirty = 1'b1;
		end else begin
			new_line.dirty = hit && rd_line_s1.dirty;
		end

		res_next.page_number       = tag_s1;
		res_next.hit               = hit;
		res_next.writeback         = wb;
		res_next.writeback_channel = wb ? pcwb_pkg::chan_sat(
			pcwb_pkg::CHAN_IN_W'(victim_addr), channel_shift, CHAN_TOP) : '0;
		res_next.fetch             = fe;
		res_next.fetch_channel     = fe ? pcwb_pkg::chan_sat(
			pcwb_pkg::CHAN_IN_W'(entry_s1.addr), channel_shift, CHAN_TOP) : '0;
		res_next.last              = entry_s1.last;

		mem_we    = (state_q == B_CLEAR) || (state_q == B_EVAL);
		mem_waddr = (state_q == B_CLEAR) ? clr_q : line_s1;
		mem_wdata = (state_q == B_CLEAR) ? line_t'('0) : new_line;
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		rd_line_s1 <= mem[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= B_CLEAR;
			clr_q          <= '0;
			result_valid_q <= 1'b0;
		end else begin
			result_valid_q <= 1'b0;
			case (state_q)
				B_CLEAR: begin
					clr_q <= clr_q + LINE_W'(1);
					if (clr_q == LINE_W'(LINES - 1)) begin
						state_q <= B_LOOK;
					end
				end
				B_LOOK: begin
					if (!fifo_stat.empty) begin
						entry_s1 <= head;
						state_q  <= B_EVAL;
					end
				end
				B_EVAL: begin
					result_q       <= res_next;
					result_valid_q <= 1'b1;
					state_q        <= B_LOOK;
				end
				default: begin
					state_q <= B_CLEAR;
				end
			endcase
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

	a_result_after_eval: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid_q |-> $past(state_q == B_EVAL))
		else $error("result strobe without a preceding line update");

	a_hit_no_miss_actions: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid_q && result_q.hit) |-> (!result_q.writeback && !result_q.fetch))
		else $error("hit reported together with writeback or fetch");

	a_no_pop_while_clearing: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == B_CLEAR) |-> (!pop && !result_valid_q))
		else $error("page access taken during the clearing pass");

	a_channels_zero_when_idle: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid_q |-> ((result_q.writeback || result_q.writeback_channel == '0) &&
			(result_q.fetch || result_q.fetch_channel == '0)))
		else $error("channel given without its writeback or fetch");

endmodule

// ===== rtl/page_cache_writeback_controller_top.sv =====
// ----------------------------------------------------------------------------
// page_cache_writeback_controller_top
// Direct-mapped write-back page cache controller: splits read and write
// commands into page accesses and reports hit, writeback and fetch per page.
// ----------------------------------------------------------------------------
//
// Channel      Ports                          Handshake
// ------------ ------------------------------ ---------------------------------
// command      start, cmd, busy               beat taken when start && !busy
// result       result_valid, result           one-cycle strobe, cannot stall
// config       cfg_we, cfg_wdata              written when cfg_we is high
//
// After reset the line store (tags and dirty bits) is cleared in a pass over
// all LINES lines, one line per cycle; busy stays high during that pass.
// A command of n pages (n = ceil(length_bytes / PAGE_BYTES), at most MAX_PAGES)
// accepted on an idle block holds busy until its last page is queued. The
// front pushes one page per cycle while the four-entry page queue is not
// full; once it is full the front pushes only as the back pops.
// The back takes each page through two states: B_LOOK takes the page from
// the queue and reads the cache line from the line store memory, and B_EVAL
// compares, updates the line and registers the result.
// Because the receiver cannot stall, only a full page queue holds the
// front back, and busy then stays high until the front has queued the last
// page of the command.
// Configuration (channel_shift) is to be written only when the block is idle.
// LINES and PAGE_BYTES must be powers of two; the block does not check this.
// ----------------------------------------------------------------------------
module page_cache_writeback_controller_top #(
	parameter int LINES      = 128,
	parameter int PAGE_BYTES = 16384,
	parameter int CHANNELS   = 4,
	parameter int MAX_PAGES  = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  pcwb_pkg::cmd_t               cmd,
	output logic                         busy,
	output logic                         result_valid,
	output pcwb_pkg::res_t               result,
	input  logic                         cfg_we,
	input  logic [pcwb_pkg::SHIFT_W-1:0] cfg_wdata
);

	// Log2 of the bytes per flash channel, used by the back for both the
	// victim channel and the fetch channel.
	logic [pcwb_pkg::SHIFT_W-1:0] channel_shift_q;

	pcwb_pkg::page_push_t  push;
	pcwb_pkg::fifo_stat_t  fifo_stat;
	pcwb_pkg::page_req_t   head;
	logic                  pop;
	logic                  clearing;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			channel_shift_q <= pcwb_pkg::CHANNEL_SHIFT_RESET;
		end else if (cfg_we) begin
			channel_shift_q <= cfg_wdata;
		end
	end

	// The front turns each command beat into page accesses.
	pcwb_front #(
		.PAGE_BYTES (PAGE_BYTES),
		.MAX_PAGES  (MAX_PAGES)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.cmd       (cmd),
		.clearing  (clearing),
		.fifo_stat (fifo_stat),
		.push      (push),
		.busy      (busy)
	);

	// The queue lets the front run ahead of the line updates.
	pcwb_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.pop    (pop),
		.head   (head),
		.stat   (fifo_stat)
	);

	// The back owns the line store and produces one result per page.
	pcwb_back #(
		.LINES      (LINES),
		.PAGE_BYTES (PAGE_BYTES),
		.CHANNELS   (CHANNELS)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.channel_shift (channel_shift_q),
		.head          (head),
		.fifo_stat     (fifo_stat),
		.pop           (pop),
		.clearing      (clearing),
		.result_valid  (result_valid),
		.result        (result)
	);

endmodule

// ===== tb/page_cache_writeback_controller_top_tb.sv =====
// ----------------------------------------------------------------------------
// page_cache_writeback_controller_top_tb
// Self-checking bench for the page cache writeback controller. Commands go in
// through the start/busy handshake, and a cycle-free predictor keeps its own
// line tags, dirty bits and channel shift to work out the result of every
// page. Each result beat is compared field by field with the oldest
// prediction. Directed cases cover reset tags, empty and full-length commands,
// evictions, address wrap and channel saturation. Random traffic is
// concentrated on the 32 lowest lines so that hits, writebacks and fetches are all
// common, and it runs under several channel shifts and sender idle rates.
// ----------------------------------------------------------------------------
module page_cache_writeback_controller_top_tb;

	localparam int LINES      = 128;
	localparam int PAGE_BYTES = 16384;
	localparam int CHANNELS   = 4;
	localparam int MAX_PAGES  = 16;
	localparam int MAX_LEN    = 262144;

	// Settling time, sized for a worst-case command of sixteen pages and the pipeline.
	localparam int DRAIN_CYCLES = 40;
	// Cycles with no beat in either direction before the run is declared hung.
	// The clearing pass after reset and the longest idle gap are far below it.
	localparam int STALL_LIMIT  = 2000;

	logic                         clk = 1'b0;
	logic                         arst_n = 1'b0;
	logic                         start = 1'b0;
	pcwb_pkg::cmd_t               cmd = '0;
	logic                         busy;
	logic                         result_valid;
	pcwb_pkg::res_t               result;
	logic                         cfg_we = 1'b0;
	logic [pcwb_pkg::SHIFT_W-1:0] cfg_wdata = '0;

	// Predictor state: what the line store and the register should hold.
	logic [pcwb_pkg::TAG_W-1:0]   line_tag [LINES];
	logic                         line_dirty [LINES];
	logic [pcwb_pkg::SHIFT_W-1:0] channel_shift = pcwb_pkg::CHANNEL_SHIFT_RESET;

	// Results predicted but not yet seen, oldest first.
	pcwb_pkg::res_t pending_pages[$];
	int   mismatches = 0;
	int   stall_cycles = 0;

	always #5 clk = ~clk;

	page_cache_writeback_controller_top #(
		.LINES(LINES),
		.PAGE_BYTES(PAGE_BYTES),
		.CHANNELS(CHANNELS),
		.MAX_PAGES(MAX_PAGES)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.cmd(cmd),
		.busy(busy),
		.result_valid(result_valid),
		.result(result),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	initial begin
		for (int i = 0; i < LINES; i++) begin
			line_tag[i] = '0;
			line_dirty[i] = 1'b0;
		end
	end

	// Flash channel of an address: shifted right and held at the top channel.
	function automatic logic [pcwb_pkg::CH_W-1:0] flash_channel(input logic [63:0] a);
		logic [63:0] s;
		s = a >> channel_shift;
		if (s > 64'(CHANNELS - 1)) begin
			s = 64'(CHANNELS - 1);
		end
		return s[pcwb_pkg::CH_W-1:0];
	endfunction

	// Walks the pages of one accepted command through the line store and queues
	// one result per page. A zero tag matches page 0, since lines carry no
	// valid bit, and a read miss leaves the line clean.
	function automatic void predict_command(input pcwb_pkg::cmd_t c);
		logic [pcwb_pkg::ADDR_W-1:0] addr;
		logic [31:0]                 page;
		int                          line;
		int                          n;
		pcwb_pkg::res_t              r;
		n = (int'(c.length_bytes) + PAGE_BYTES - 1) / PAGE_BYTES;
		if (n > MAX_PAGES) begin
			n = MAX_PAGES;
		end
		addr = c.byte_address;
		for (int k = 0; k < n; k++) begin
			page = addr / PAGE_BYTES;
			line = page % LINES;
			r = '0;
			r.page_number = page[pcwb_pkg::TAG_W-1:0];
			r.last = (k == n - 1);
			if (line_tag[line] == page[pcwb_pkg::TAG_W-1:0]) begin
				r.hit = 1'b1;
			end else begin
				if (line_dirty[line]) begin
					// The victim's channel comes from the tag before it is replaced.
					r.writeback = 1'b1;
					r.writeback_channel = flash_channel(64'(line_tag[line]) * PAGE_BYTES);
				end
				line_tag[line] = page[pcwb_pkg::TAG_W-1:0];
				if (c.op == pcwb_pkg::OP_READ) begin
					r.fetch = 1'b1;
					r.fetch_channel = flash_channel(64'(addr));
					line_dirty[line] = 1'b0;
				end
			end
			if (c.op == pcwb_pkg::OP_WRITE) begin
				line_dirty[line] = 1'b1;
			end
			pending_pages.push_back(r);
			addr = addr + pcwb_pkg::ADDR_W'(PAGE_BYTES);
		end
	endfunction

	task automatic report_mismatch(input string what, input longint got, input longint want);
		$display("%0t: mismatch in %s: got %0d, expected %0d", $time, what, got, want);
		mismatches++;
	endtask

	task automatic check_result(input pcwb_pkg::res_t got);
		pcwb_pkg::res_t want;
		if (pending_pages.size() == 0) begin
			report_mismatch("unexpected result page_number", got.page_number, -1);
		end else begin
			want = pending_pages.pop_front();
			if (got.page_number !== want.page_number)
				report_mismatch("page_number", got.page_number, want.page_number);
			if (got.hit !== want.hit)
				report_mismatch("hit", got.hit, want.hit);
			if (got.writeback !== want.writeback)
				report_mismatch("writeback", got.writeback, want.writeback);
			if (got.writeback_channel !== want.writeback_channel)
				report_mismatch("writeback_channel", got.writeback_channel,
					want.writeback_channel);
			if (got.fetch !== want.fetch)
				report_mismatch("fetch", got.fetch, want.fetch);
			if (got.fetch_channel !== want.fetch_channel)
				report_mismatch("fetch_channel", got.fetch_channel, want.fetch_channel);
			if (got.last !== want.last)
				report_mismatch("last", got.last, want.last);
		end
	endtask

	// Both handshakes are sampled at the rising edge, before any nonblocking
	// update of that edge lands, so the values seen are those held during the
	// cycle that the edge ends. The stall counter feeds the watchdog.
	always @(posedge clk) begin
		if (start && !busy) begin
			predict_command(cmd);
		end
		if (result_valid) begin
			check_result(result);
		end
		if ((start && !busy) || result_valid) begin
			stall_cycles <= 0;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	initial begin
		wait (stall_cycles >= STALL_LIMIT);
		$display("%0t: no beat for %0d cycles", $time, STALL_LIMIT);
		$display("*** FAILED ***");
		$finish;
	end

	function automatic logic [pcwb_pkg::ADDR_W-1:0] page_base(input int page);
		return pcwb_pkg::ADDR_W'(page) * PAGE_BYTES;
	endfunction

	// Sends one command beat. Before raising start the sender may idle for a
	// random number of cycles. The task returns at the edge that took the beat
	// with start still high, so a following beat can go out back to back
	// without start dropping in between.
	task automatic send_cmd(input logic op, input logic [pcwb_pkg::ADDR_W-1:0] addr,
			input logic [pcwb_pkg::LEN_W-1:0] len, input int idle_pct);
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		cmd <= '{op: op, byte_address: addr, length_bytes: len};
		forever begin
			@(posedge clk);
			if (!busy) begin
				break;
			end
		end
	endtask

	// Stops sending and waits until every predicted result has come and busy
	// has dropped, then gives the back end time to settle.
	task automatic wait_for_idle();
		start <= 1'b0;
		do begin
			@(posedge clk);
		end while (pending_pages.size() != 0 || busy);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic set_channel_shift(input logic [pcwb_pkg::SHIFT_W-1:0] value);
		wait_for_idle();
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		channel_shift = value;
	endtask

	// Page 0 must hit on line 0 straight after reset, since the cleared tag is 0.
	task automatic test_reset_tag_hit();
		send_cmd(pcwb_pkg::OP_READ, 32'h0, 19'd1, 0);
		send_cmd(pcwb_pkg::OP_WRITE, 32'h0000_3FFF, pcwb_pkg::LEN_W'(PAGE_BYTES), 0);
	endtask

	task automatic test_zero_length();
		send_cmd(pcwb_pkg::OP_READ, 32'h1234_5678, 19'd0, 0);
		send_cmd(pcwb_pkg::OP_WRITE, 32'hFFFF_FFFF, 19'd0, 0);
	endtask

	// Conflicting pages on line 0 and line 127: dirty victims are written back,
	// and a read miss fetches and leaves the line clean. The top page of the
	// address space gives a victim channel far above the top channel.
	task automatic test_eviction();
		send_cmd(pcwb_pkg::OP_WRITE, page_base(LINES), 19'd1, 0);
		send_cmd(pcwb_pkg::OP_READ, page_base(2 * LINES) + 32'd77, 19'd100, 0);
		send_cmd(pcwb_pkg::OP_WRITE, 32'hFFFF_C000, 19'd1, 0);
		send_cmd(pcwb_pkg::OP_READ, page_base(LINES - 1), 19'd1, 0);
	endtask

	// Page counts round up, up to the full sixteen pages.
	task automatic test_page_count();
		send_cmd(pcwb_pkg::OP_WRITE, 32'h1234_5678, pcwb_pkg::LEN_W'(MAX_LEN), 0);
		send_cmd(pcwb_pkg::OP_READ, 32'h1234_5678, pcwb_pkg::LEN_W'(MAX_LEN - 1), 0);
		send_cmd(pcwb_pkg::OP_READ, 32'h0040_0000, pcwb_pkg::LEN_W'(PAGE_BYTES + 1), 0);
		send_cmd(pcwb_pkg::OP_WRITE, 32'h0040_0000, pcwb_pkg::LEN_W'(PAGE_BYTES), 0);
		send_cmd(pcwb_pkg::OP_READ, 32'h0080_0000, 19'h2AAAA, 0);
	endtask

	// Page addresses wrap at 32 bits, so the top page is followed by page 0.
	task automatic test_address_wrap();
		send_cmd(pcwb_pkg::OP_READ, 32'hFFFF_FFFF, pcwb_pkg::LEN_W'(3 * PAGE_BYTES), 0);
		send_cmd(pcwb_pkg::OP_WRITE, 32'hFFFF_8000, pcwb_pkg::LEN_W'(4 * PAGE_BYTES), 0);
		send_cmd(pcwb_pkg::OP_READ, 32'h5555_5555, 19'h15555, 0);
	endtask

	// With the smallest shift nearly every address lands past the top channel.
	// With the largest shift only the top address bit picks the channel.
	task automatic test_channel_saturation();
		set_channel_shift(5'd14);
		send_cmd(pcwb_pkg::OP_WRITE, page_base(200) + 32'd5, 19'd1, 0);
		send_cmd(pcwb_pkg::OP_READ, page_base(200 + 3 * LINES), 19'd1, 0);
		set_channel_shift(5'd31);
		send_cmd(pcwb_pkg::OP_WRITE, 32'h8000_0000, 19'd1, 0);
		send_cmd(pcwb_pkg::OP_READ, 32'h0000_0000, pcwb_pkg::LEN_W'(2 * PAGE_BYTES), 0);
		send_cmd(pcwb_pkg::OP_READ, 32'hC000_0000, 19'd1, 0);
	endtask

	// Most commands reuse a handful of tags on the low lines so that hits,
	// dirty evictions and fetches keep happening. The rest are any address and
	// any length, including empty and full-length commands.
	task automatic test_random_traffic(input logic [pcwb_pkg::SHIFT_W-1:0] shift,
			input int count, input int idle_pct);
		int                          tag_groups[5] = '{0, 1, 5, 12, 2047};
		int                          kind;
		logic [pcwb_pkg::ADDR_W-1:0] addr;
		logic [pcwb_pkg::LEN_W-1:0]  len;
		set_channel_shift(shift);
		for (int i = 0; i < count; i++) begin
			kind = $urandom_range(99);
			if (kind < 80) begin
				addr = page_base(tag_groups[$urandom_range(4)] * LINES + $urandom_range(31))
					+ $urandom_range(PAGE_BYTES - 1);
				if (kind < 4) begin
					len = '0;
				end else if (kind < 10) begin
					len = pcwb_pkg::LEN_W'($urandom_range(MAX_LEN));
				end else begin
					len = pcwb_pkg::LEN_W'($urandom_range(4 * PAGE_BYTES, 1));
				end
			end else begin
				addr = $urandom;
				len = pcwb_pkg::LEN_W'($urandom_range(MAX_LEN));
			end
			send_cmd(1'($urandom_range(1)), addr, len, idle_pct);
		end
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// The directed cases up to the address wrap run under the reset value of the channel shift.
		test_reset_tag_hit();
		test_zero_length();
		test_eviction();
		test_page_count();
		test_address_wrap();
		test_channel_saturation();

		// Sender idles often first, then more often, then never.
		test_random_traffic(5'd17, 70, 21);
		test_random_traffic(5'd31, 70, 21);
		test_random_traffic(5'd14, 70, 46);
		test_random_traffic(5'd21, 70, 46);
		test_random_traffic(5'd23, 70, 0);
		test_random_traffic(5'd16, 70, 0);

		wait_for_idle();
		if (pending_pages.size() != 0) begin
			report_mismatch("results still outstanding", 0, pending_pages.size());
		end
		if (mismatches == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
